### hdl/gcc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the greedy coin change block.
// No dependencies; used by gcc_cell and greedy_coin_change.
package gcc_pkg;

    localparam int COIN_W    = 16;
    localparam int SLOT_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int REG_COUNT = 5;
    localparam int SLOT_MAX  = 8;
    localparam int STEP_W    = $clog2(COIN_W);

    localparam logic [COIN_W-1:0] COIN_RESET [SLOT_MAX] = '{
        16'd50, 16'd10, 16'd5, 16'd2, 16'd1, 16'd1, 16'd1, 16'd1
    };

    typedef enum logic [1:0] {
        CELL_IDLE,
        CELL_DIV,
        CELL_FIN
    } cell_state_t;

    // What a cell hands to its right neighbor and to the output stage.
    typedef struct packed {
        logic              done;
        logic [COIN_W-1:0] coin;
        logic [COIN_W-1:0] count;
        logic [COIN_W-1:0] rem;
    } cell_res_t;

    function automatic logic [COIN_W-1:0] coin_reset_value(input int k);
        logic [COIN_W-1:0] v;
        v = COIN_RESET[k];
        return v;
    endfunction

endpackage

### hdl/greedy_coin_change.sv
`timescale 1ns / 1ps
// Greedy coin change: top level with the cell chain and the result register.
// Depends on gcc_pkg and gcc_cell.
//
// Usage: raise start with an amount while busy is low; the beat is taken at
// that edge and busy rises. The amount enters the first cell, which divides
// it by its coin value, one quotient bit per cycle, then hands the remainder
// to the next cell. Each cell runs 16 divide steps and then a hand-off state;
// a zero coin value skips the divide steps and goes straight to the hand-off.
// One result per slot appears on slot/coin_value/coin_count/shortfall/last,
// marked by done for exactly one cycle; the receiver cannot stall it.
// Results come out in slot order through the output register, as each cell
// finishes its divide. busy falls while the last result is presented, so a
// new amount may be taken at the edge that takes that beat.
// shortfall is nonzero only on the result with last set.
// Coin values are written through cfg_we/cfg_index/cfg_data while idle;
// indexes of 5 or more are ignored. Reset loads 50, 10, 5, 2, 1 (extra slots
// hold 1), and clears busy and done.
module greedy_coin_change #(
    parameter int NUM_COINS = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [gcc_pkg::COIN_W-1:0]    amount,
    input  logic                          cfg_we,
    input  logic [gcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gcc_pkg::COIN_W-1:0]    cfg_data,
    output logic                          done,
    output logic [gcc_pkg::SLOT_W-1:0]    slot,
    output logic [gcc_pkg::COIN_W-1:0]    coin_value,
    output logic [gcc_pkg::COIN_W-1:0]    coin_count,
    output logic [gcc_pkg::COIN_W-1:0]    shortfall,
    output logic                          last
);
    import gcc_pkg::*;

    logic               accept;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [COIN_W-1:0]  coin_value_reg, coin_value_next;
    logic [COIN_W-1:0]  coin_count_reg, coin_count_next;
    logic [COIN_W-1:0]  shortfall_reg, shortfall_next;
    logic               last_reg, last_next;
    cell_res_t          cell_res [NUM_COINS];
    logic [NUM_COINS-1:0] cell_done_vec;

    assign accept = start & ~busy_reg;

    for (genvar k = 0; k < NUM_COINS; k++)
    begin : g_cell
        logic              cell_go;
        logic [COIN_W-1:0] cell_rem_in;
        logic              cell_we;

        if (k == 0)
        begin : g_head
            assign cell_go     = accept;
            assign cell_rem_in = amount;
        end
        else
        begin : g_link
            assign cell_go     = cell_res[k-1].done;
            assign cell_rem_in = cell_res[k-1].rem;
        end

        // slots past the register list are fixed
        assign cell_we = cfg_we && (k < REG_COUNT) && (cfg_index == CFG_IDX_W'(k));
        assign cell_done_vec[k] = cell_res[k].done;

        gcc_cell #(
            .RESET_VALUE (coin_reset_value(k))
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg_we   (cell_we),
            .cfg_data (cfg_data),
            .go       (cell_go),
            .rem_in   (cell_rem_in),
            .res      (cell_res[k])
        );
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (cell_res[NUM_COINS-1].done)
        begin
            busy_next = 1'b0;
        end
    end

    // only one cell finishes in any cycle
    always_comb
    begin
        done_next       = |cell_done_vec;
        slot_next       = slot_reg;
        coin_value_next = coin_value_reg;
        coin_count_next = coin_count_reg;
        shortfall_next  = shortfall_reg;
        last_next       = last_reg;
        for (int k = 0; k < NUM_COINS; k++)
        begin
            if (cell_res[k].done)
            begin
                slot_next       = SLOT_W'(k);
                coin_value_next = cell_res[k].coin;
                coin_count_next = cell_res[k].count;
                shortfall_next  = (k == NUM_COINS - 1) ? cell_res[k].rem : '0;
                last_next       = (k == NUM_COINS - 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        coin_value_reg <= coin_value_next;
        coin_count_reg <= coin_count_next;
        shortfall_reg  <= shortfall_next;
        last_reg       <= last_next;
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign slot       = slot_reg;
    assign coin_value = coin_value_reg;
    assign coin_count = coin_count_reg;
    assign shortfall  = shortfall_reg;
    assign last       = last_reg;

    a_one_cell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_done_vec))
        else $error("more than one cell finished in a cycle");

    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && last_reg) |-> (slot_reg == SLOT_W'(NUM_COINS - 1)))
        else $error("last beat not on final slot");

    a_shortfall_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !last_reg) |-> (shortfall_reg == '0))
        else $error("shortfall on a non-final beat");

    a_busy_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("busy not raised after start");

    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (|cell_done_vec) |-> busy_reg)
        else $error("cell finished while idle");

endmodule

### hdl/gcc_cell.sv
`timescale 1ns / 1ps
// One coin slot: holds its coin value and runs a bit-serial restoring divide
// of the incoming remainder. Depends on gcc_pkg.
module gcc_cell #(
    parameter logic [gcc_pkg::COIN_W-1:0] RESET_VALUE = 16'd1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [gcc_pkg::COIN_W-1:0]  cfg_data,
    input  logic                        go,
    input  logic [gcc_pkg::COIN_W-1:0]  rem_in,
    output gcc_pkg::cell_res_t          res
);
    import gcc_pkg::*;

    cell_state_t        state_reg, state_next;
    logic [COIN_W-1:0]  coin_reg;
    logic [COIN_W-1:0]  q_reg, q_next;
    logic [COIN_W-1:0]  r_reg, r_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [COIN_W+1:0]  diff;
    logic               ge;
    logic               coin_zero;

    assign coin_zero = (coin_reg == '0);

    // trial subtract of the shifted partial remainder
    assign diff = {1'b0, r_reg, q_reg[COIN_W-1]} - {2'b00, coin_reg};
    assign ge   = ~diff[COIN_W+1];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CELL_IDLE:
            begin
                if (go)
                begin
                    state_next = coin_zero ? CELL_FIN : CELL_DIV;
                end
            end
            CELL_DIV:
            begin
                if (cnt_reg == STEP_W'(COIN_W - 1))
                begin
                    state_next = CELL_FIN;
                end
            end
            CELL_FIN:
            begin
                state_next = CELL_IDLE;
            end
            default:
            begin
                state_next = CELL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_next   = q_reg;
        r_next   = r_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            CELL_IDLE:
            begin
                cnt_next = '0;
                if (go)
                begin
                    // zero coin pays nothing, amount passes straight on
                    q_next = coin_zero ? '0 : rem_in;
                    r_next = coin_zero ? rem_in : '0;
                end
            end
            CELL_DIV:
            begin
                q_next   = {q_reg[COIN_W-2:0], ge};
                r_next   = ge ? diff[COIN_W-1:0] : {r_reg[COIN_W-2:0], q_reg[COIN_W-1]};
                cnt_next = cnt_reg + STEP_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.done  = (state_reg == CELL_FIN);
        res.coin  = coin_reg;
        res.count = q_reg;
        res.rem   = r_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CELL_IDLE;
            coin_reg  <= RESET_VALUE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                coin_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for greedy_coin_change: queue-fed driver, clocked monitor, payout predictor.
// Depends on gcc_pkg and the greedy_coin_change RTL under hdl/.
module tb;

    localparam int NUM_COINS   = 5;
    localparam int CW          = gcc_pkg::COIN_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 120;

    // One pending beat for the driver: a coin register write or an amount.
    typedef struct packed {
        logic                          is_cfg;
        logic [gcc_pkg::CFG_IDX_W-1:0] idx;
        logic [CW-1:0]                 data;
        logic [CW-1:0]                 amt;
        logic [7:0]                    idle_pct;
    } disp_op_t;

    typedef struct packed {
        logic [gcc_pkg::SLOT_W-1:0] slot;
        logic [CW-1:0]              coin_value;
        logic [CW-1:0]              coin_count;
        logic [CW-1:0]              shortfall;
        logic                       last;
    } coin_res_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          start     = 1'b0;
    logic [CW-1:0]                 amount    = '0;
    logic                          cfg_we    = 1'b0;
    logic [gcc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [CW-1:0]                 cfg_data  = '0;
    logic                          busy;
    logic                          done;
    logic [gcc_pkg::SLOT_W-1:0]    slot;
    logic [CW-1:0]                 coin_value;
    logic [CW-1:0]                 coin_count;
    logic [CW-1:0]                 shortfall;
    logic                          last;

    disp_op_t  pending_q [$];
    coin_res_t payout_q [$];
    logic [CW-1:0] coin_tbl [gcc_pkg::SLOT_MAX] = gcc_pkg::COIN_RESET;

    int issue_cnt   = 0;
    int accept_cnt  = 0;
    int cfg_writes  = 0;
    int results_ok  = 0;
    int err_cnt     = 0;
    int cycle_cnt   = 0;

    greedy_coin_change #(
        .NUM_COINS(NUM_COINS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .amount(amount),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .done(done),
        .slot(slot),
        .coin_value(coin_value),
        .coin_count(coin_count),
        .shortfall(shortfall),
        .last(last)
    );

    always #5 clk = ~clk;

    // Greedy split of one amount over the shadow coin table, slot order.
    function automatic void plan_payout(input logic [CW-1:0] amt);
        logic [CW-1:0] rest;
        logic [CW-1:0] coin;
        logic [CW-1:0] cnt;
        coin_res_t     r;
        rest = amt;
        for (int k = 0; k < NUM_COINS; k++)
        begin
            coin = coin_tbl[k];
            cnt  = '0;
            if (coin != '0)
            begin
                cnt  = rest / coin;
                rest = rest % coin;
            end
            r.slot       = k[gcc_pkg::SLOT_W-1:0];
            r.coin_value = coin;
            r.coin_count = cnt;
            r.last       = (k == NUM_COINS - 1);
            r.shortfall  = r.last ? rest : '0;
            payout_q     = {payout_q, r};
        end
    endfunction

    function automatic void push_amount(input logic [CW-1:0] amt, input int pct);
        disp_op_t op;
        op          = '0;
        op.amt      = amt;
        op.idle_pct = pct[7:0];
        pending_q   = {pending_q, op};
    endfunction

    function automatic void push_coin_write(input int idx, input logic [CW-1:0] data);
        disp_op_t op;
        op        = '0;
        op.is_cfg = 1'b1;
        op.idx    = idx[gcc_pkg::CFG_IDX_W-1:0];
        op.data   = data;
        pending_q = {pending_q, op};
    endfunction

    function automatic void push_coin_set(input logic [CW-1:0] v0, input logic [CW-1:0] v1,
                                          input logic [CW-1:0] v2, input logic [CW-1:0] v3,
                                          input logic [CW-1:0] v4);
        push_coin_write(0, v0);
        push_coin_write(1, v1);
        push_coin_write(2, v2);
        push_coin_write(3, v3);
        push_coin_write(4, v4);
    endfunction

    function automatic logic [CW-1:0] rand_coin();
        logic [CW-1:0] v;
        case ($urandom_range(9))
            0:       v = '0;
            1:       v = 16'hFFFF;
            2, 3:    v = CW'($urandom_range(1, 20));
            4, 5:    v = CW'($urandom_range(1, 1000));
            default: v = CW'($urandom_range(1, 65535));
        endcase
        return v;
    endfunction

    function automatic logic [CW-1:0] rand_amount();
        logic [CW-1:0] v;
        case ($urandom_range(3))
            0:       v = CW'($urandom_range(0, 255));
            1:       v = CW'($urandom_range(0, 4095));
            2:       v = CW'(32'h0000_FFFF - $urandom_range(0, 15));
            default: v = CW'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    // Driver: inputs move on the falling edge; start holds until the beat is taken.
    always @(negedge clk)
    begin
        disp_op_t                      op;
        logic                          nxt_start;
        logic                          nxt_we;
        logic [gcc_pkg::CFG_IDX_W-1:0] nxt_idx;
        logic [CW-1:0]                 nxt_data;
        logic [CW-1:0]                 nxt_amt;
        nxt_start = start;
        nxt_we    = 1'b0;
        nxt_idx   = cfg_index;
        nxt_data  = cfg_data;
        nxt_amt   = amount;
        if (!rst_n)
            nxt_start = 1'b0;
        else if (issue_cnt == accept_cnt)
        begin
            nxt_start = 1'b0;
            if (pending_q.size() != 0)
            begin
                op = pending_q[0];
                if (op.is_cfg)
                begin
                    // coin writes only once the previous payout has fully drained
                    if (payout_q.size() == 0 && !busy)
                    begin
                        nxt_we   = 1'b1;
                        nxt_idx  = op.idx;
                        nxt_data = op.data;
                        void'(pending_q.pop_front());
                    end
                end
                else if ($urandom_range(99) >= op.idle_pct)
                begin
                    nxt_start = 1'b1;
                    nxt_amt   = op.amt;
                    void'(pending_q.pop_front());
                    issue_cnt++;
                end
            end
        end
        start     <= nxt_start;
        cfg_we    <= nxt_we;
        cfg_index <= nxt_idx;
        cfg_data  <= nxt_data;
        amount    <= nxt_amt;
    end

    // Monitor: register writes, accepted amounts and result beats at the rising edge.
    always @(posedge clk)
    begin
        coin_res_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index < gcc_pkg::REG_COUNT)
                    coin_tbl[cfg_index] = cfg_data;
                cfg_writes++;
            end
            if (start && !busy)
            begin
                plan_payout(amount);
                accept_cnt++;
            end
            if (done)
            begin
                if (payout_q.size() == 0)
                begin
                    $error("result beat with nothing expected: slot %0d", slot);
                    err_cnt++;
                end
                else
                begin
                    want = payout_q.pop_front();
                    if (slot !== want.slot)
                    begin
                        $error("slot: expected %0d, actual %0d", want.slot, slot);
                        err_cnt++;
                    end
                    if (coin_value !== want.coin_value)
                    begin
                        $error("coin_value: expected %0d, actual %0d", want.coin_value,
                               coin_value);
                        err_cnt++;
                    end
                    if (coin_count !== want.coin_count)
                    begin
                        $error("coin_count: expected %0d, actual %0d", want.coin_count,
                               coin_count);
                        err_cnt++;
                    end
                    if (shortfall !== want.shortfall)
                    begin
                        $error("shortfall: expected %0d, actual %0d", want.shortfall,
                               shortfall);
                        err_cnt++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, last);
                        err_cnt++;
                    end
                    results_ok++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        logic [CW-1:0] cv [NUM_COINS];
        logic [CW-1:0] tmp;
        int            pct;

        // reset coin table, field extremes and alternating bit patterns
        push_amount(16'd0, 15);
        push_amount(16'd1, 15);
        push_amount(16'd49, 15);
        push_amount(16'd88, 15);
        push_amount(16'd12345, 15);
        push_amount(16'hFFFF, 15);
        push_amount(16'h5555, 15);
        push_amount(16'hAAAA, 15);
        // zero coins pass the rest through; writes above index 4 must be dropped
        push_coin_set(16'd0, 16'd7, 16'd0, 16'hFFFF, 16'd3);
        push_coin_write(5, 16'hFFFF);
        push_coin_write(6, 16'h0000);
        push_coin_write(7, 16'hFFFF);
        push_amount(16'hFFFF, 15);
        push_amount(16'd100, 15);
        push_amount(16'd2, 15);
        // out-of-order coins leave a shortfall
        push_coin_set(16'd1000, 16'd60000, 16'd7, 16'd13, 16'd9);
        push_amount(16'hFFFF, 15);
        push_amount(16'd59999, 15);
        push_amount(16'd4, 15);
        push_coin_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_amount(16'hFFFE, 15);
        push_amount(16'hFFFF, 15);
        push_coin_set(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        push_amount(16'hFFFF, 15);
        push_amount(16'd12, 15);
        push_coin_set(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        push_amount(16'hFFFF, 15);
        push_amount(16'd0, 15);

        for (int ph = 0; ph < 12; ph++)
        begin
            pct = (ph < 4) ? 15 : (ph < 8) ? 45 : 0;
            for (int j = 0; j < NUM_COINS; j++)
                cv[j] = rand_coin();
            // half the settings use the usual largest-first order
            if ($urandom_range(1))
            begin
                for (int a = 0; a < NUM_COINS - 1; a++)
                    for (int b = 0; b < NUM_COINS - 1 - a; b++)
                        if (cv[b] < cv[b+1])
                        begin
                            tmp     = cv[b];
                            cv[b]   = cv[b+1];
                            cv[b+1] = tmp;
                        end
            end
            push_coin_set(cv[0], cv[1], cv[2], cv[3], cv[4]);
            if ($urandom_range(3) == 0)
                push_coin_write(int'($urandom_range(5, 7)), CW'($urandom_range(0, 65535)));
            for (int i = 0; i < 21; i++)
                push_amount(rand_amount(), pct);
        end

        while (pending_q.size() != 0 || issue_cnt != accept_cnt || payout_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d amounts, %0d slot results, %0d coin register writes",
                 accept_cnt, results_ok, cfg_writes);
        $display("Coin tables covered reset values, zeros, unsorted coins and full scale");
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
